// File: rtl/opp_pkg.sv
// Shared types, constants and the CRC step for the Ogg page parser.
// No dependencies; every module imports this package.
package opp_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        K_PACKET      = 3'd0,
        K_SUMMARY     = 3'd1,
        K_BAD_CAPTURE = 3'd2,
        K_BAD_VERSION = 3'd3,
        K_TRUNC       = 3'd4
    } t_kind;

    // Parser phases, one-hot
    typedef enum logic [3:0] {
        PH_HDR  = 4'b0001,
        PH_LACE = 4'b0010,
        PH_BODY = 4'b0100,
        PH_HUNT = 4'b1000
    } t_phase;

    localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [7:0]  LACE_FULL    = 8'hFF;
    localparam logic [4:0]  VERSION_AT   = 5'd4;
    localparam logic [4:0]  TYPE_AT      = 5'd5;
    localparam logic [4:0]  CRC_FIELD_AT = 5'd22;
    localparam logic [4:0]  SEGCOUNT_AT  = 5'd26;
    localparam logic [7:0]  CAPTURE [4]  = '{8'h4F, 8'h67, 8'h67, 8'h53};

    // Result queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One queue entry: every result caused by one input byte (one or two beats)
    typedef struct packed {
        logic        two;
        t_kind       kind0;
        t_kind       kind1;
        logic [15:0] len_pkt;
        logic [15:0] len_body;
        logic [7:0]  page_type;
        logic [31:0] gran_lo;
        logic [31:0] gran_hi;
        logic [31:0] serial;
        logic [31:0] sequence_no;
        logic [7:0]  seg_count;
        logic [7:0]  pkt_count;
        logic        ctail;
        logic        crc_ok;
    } t_rec;

    // Unreflected CRC-32 over one byte, MSB first
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/opp_in_if.sv
// Byte stream channel into the Ogg page parser.
// Carries valid, ready and one stream byte with its end-of-buffer mark.
interface opp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source(output valid, data_byte, end_of_buffer, input ready);
    modport sink(input valid, data_byte, end_of_buffer, output ready);
endinterface

// File: rtl/opp_out_if.sv
// Result channel out of the Ogg page parser.
// Carries valid, ready and one result item.
interface opp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] length;
    logic        last_of_run;
    logic [7:0]  page_type;
    logic [31:0] granule_low;
    logic [31:0] granule_high;
    logic [31:0] stream_serial;
    logic [31:0] page_sequence;
    logic [7:0]  segment_count;
    logic [7:0]  packet_count;
    logic        continued_tail;
    logic        crc_ok;

    modport source(output valid, kind, length, last_of_run, page_type, granule_low,
                   granule_high, stream_serial, page_sequence, segment_count,
                   packet_count, continued_tail, crc_ok, input ready);
    modport sink(input valid, kind, length, last_of_run, page_type, granule_low,
                 granule_high, stream_serial, page_sequence, segment_count,
                 packet_count, continued_tail, crc_ok, output ready);
endinterface

// File: rtl/opp_front.sv
// Front end: takes stream bytes, runs the page parser and the CRC, and
// pushes one queue entry per byte that causes results. Uses opp_pkg, opp_in_if.
module opp_front
    import opp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    opp_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output t_rec           o_rec
);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_idx, n_idx;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_gran_lo, n_gran_lo;
    logic [31:0] r_gran_hi, n_gran_hi;
    logic [31:0] r_serial, n_serial;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_stored_crc, n_stored_crc;
    logic [7:0]  r_seg_total, n_seg_total;
    logic [7:0]  r_seg_left, n_seg_left;
    logic [16:0] r_body_total, n_body_total;
    logic [16:0] r_body_left, n_body_left;
    logic [15:0] r_run, n_run;
    logic [7:0]  r_packets, n_packets;
    logic        r_tail, n_tail;
    logic [31:0] r_crc, n_crc;

    logic        w_fire;
    logic [7:0]  w_b;
    logic        w_eob;
    logic [7:0]  w_crc_byte;
    logic [1:0]  w_lane;
    logic [31:0] w_lane_val;
    logic [15:0] w_run_sum;
    logic        w_has_pkt, w_has_sum, w_has_err, w_has_trunc, w_parse;
    t_kind       w_err_kind;

    assign i_in.ready = !i_full;
    assign w_fire     = i_in.valid && !i_full;
    assign w_b        = i_in.data_byte;
    assign w_eob      = i_in.end_of_buffer;
    // header fields are 4-byte groups starting at 6, 10, 14, 18, 22
    assign w_lane     = r_idx[1:0] + 2'd2;
    assign w_lane_val = {24'h000000, w_b} << {w_lane, 3'b000};
    assign w_run_sum  = r_run + {8'h00, w_b};

    always_comb begin
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_type       = r_type;
        n_gran_lo    = r_gran_lo;
        n_gran_hi    = r_gran_hi;
        n_serial     = r_serial;
        n_seq        = r_seq;
        n_stored_crc = r_stored_crc;
        n_seg_total  = r_seg_total;
        n_seg_left   = r_seg_left;
        n_body_total = r_body_total;
        n_body_left  = r_body_left;
        n_run        = r_run;
        n_packets    = r_packets;
        n_tail       = r_tail;
        n_crc        = r_crc;
        w_has_pkt    = 1'b0;
        w_has_sum    = 1'b0;
        w_has_err    = 1'b0;
        w_has_trunc  = 1'b0;
        w_parse      = 1'b0;
        w_err_kind   = K_BAD_CAPTURE;
        w_crc_byte   = w_b;

        if (w_fire) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (w_eob) begin
                        n_phase = PH_HDR;
                    end
                end
                PH_HDR: begin
                    w_parse = 1'b1;
                    // stored CRC bytes count as zero
                    if (r_idx >= CRC_FIELD_AT && r_idx < SEGCOUNT_AT) begin
                        w_crc_byte = 8'h00;
                    end
                    if (r_idx < VERSION_AT && w_b != CAPTURE[r_idx[1:0]]) begin
                        w_has_err  = 1'b1;
                        w_err_kind = K_BAD_CAPTURE;
                    end else if (r_idx == VERSION_AT && w_b != 8'h00) begin
                        w_has_err  = 1'b1;
                        w_err_kind = K_BAD_VERSION;
                    end else begin
                        case (r_idx) inside
                            TYPE_AT:        n_type       = w_b;
                            [5'd6:5'd9]:    n_gran_lo    = r_gran_lo | w_lane_val;
                            [5'd10:5'd13]:  n_gran_hi    = r_gran_hi | w_lane_val;
                            [5'd14:5'd17]:  n_serial     = r_serial | w_lane_val;
                            [5'd18:5'd21]:  n_seq        = r_seq | w_lane_val;
                            [5'd22:5'd25]:  n_stored_crc = r_stored_crc | w_lane_val;
                            default: ;
                        endcase
                        if (r_idx >= SEGCOUNT_AT) begin
                            n_seg_total = w_b;
                            n_seg_left  = w_b;
                            if (w_b == 8'h00) begin
                                w_has_sum = 1'b1;
                            end else begin
                                n_phase = PH_LACE;
                            end
                        end else begin
                            n_idx = r_idx + 5'd1;
                        end
                    end
                end
                PH_LACE: begin
                    w_parse      = 1'b1;
                    n_body_total = r_body_total + {9'h000, w_b};
                    n_run        = w_run_sum;
                    n_seg_left   = r_seg_left - 8'd1;
                    if (w_b != LACE_FULL) begin
                        n_packets = r_packets + 8'd1;
                        n_run     = 16'h0000;
                        w_has_pkt = 1'b1;
                    end
                    if (n_seg_left == 8'd0) begin
                        // a full final lacing value closes a continued tail packet
                        if (w_b == LACE_FULL) begin
                            n_packets = r_packets + 8'd1;
                            n_tail    = 1'b1;
                            n_run     = 16'h0000;
                            w_has_pkt = 1'b1;
                        end
                        if (n_body_total == 17'd0) begin
                            w_has_sum = 1'b1;
                        end else begin
                            n_body_left = n_body_total;
                            n_phase     = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    w_parse     = 1'b1;
                    n_body_left = r_body_left - 17'd1;
                    if (n_body_left == 17'd0) begin
                        w_has_sum = 1'b1;
                    end
                end
                default: ;
            endcase

            if (w_parse) begin
                n_crc = crc_step(r_crc, w_crc_byte);
            end
            w_has_trunc = w_parse && w_eob && !w_has_sum && !w_has_err;
        end

        // entry is built from the updated page state, before any restart
        o_rec.two         = w_has_pkt && (w_has_sum || w_has_trunc);
        o_rec.kind0       = w_has_err ? w_err_kind :
                            w_has_pkt ? K_PACKET :
                            w_has_sum ? K_SUMMARY : K_TRUNC;
        o_rec.kind1       = w_has_sum ? K_SUMMARY : K_TRUNC;
        o_rec.len_pkt     = w_run_sum;
        o_rec.len_body    = n_body_total[15:0];
        o_rec.page_type   = n_type;
        o_rec.gran_lo     = n_gran_lo;
        o_rec.gran_hi     = n_gran_hi;
        o_rec.serial      = n_serial;
        o_rec.sequence_no = n_seq;
        o_rec.seg_count   = n_seg_total;
        o_rec.pkt_count   = n_packets;
        o_rec.ctail       = n_tail;
        o_rec.crc_ok      = (n_stored_crc == n_crc);
        o_push            = w_has_err || w_has_pkt || w_has_sum || w_has_trunc;

        // restart the page on error, page end or truncation
        if (w_has_err || w_has_sum || w_has_trunc) begin
            n_phase      = (w_has_err && !w_eob) ? PH_HUNT : PH_HDR;
            n_idx        = 5'd0;
            n_type       = 8'h00;
            n_gran_lo    = 32'h0;
            n_gran_hi    = 32'h0;
            n_serial     = 32'h0;
            n_seq        = 32'h0;
            n_stored_crc = 32'h0;
            n_seg_total  = 8'h00;
            n_seg_left   = 8'h00;
            n_body_total = 17'd0;
            n_body_left  = 17'd0;
            n_run        = 16'h0000;
            n_packets    = 8'h00;
            n_tail       = 1'b0;
            n_crc        = 32'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR;
            r_idx        <= 5'd0;
            r_type       <= 8'h00;
            r_gran_lo    <= 32'h0;
            r_gran_hi    <= 32'h0;
            r_serial     <= 32'h0;
            r_seq        <= 32'h0;
            r_stored_crc <= 32'h0;
            r_seg_total  <= 8'h00;
            r_seg_left   <= 8'h00;
            r_body_total <= 17'd0;
            r_body_left  <= 17'd0;
            r_run        <= 16'h0000;
            r_packets    <= 8'h00;
            r_tail       <= 1'b0;
            r_crc        <= 32'h0;
        end else begin
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_type       <= n_type;
            r_gran_lo    <= n_gran_lo;
            r_gran_hi    <= n_gran_hi;
            r_serial     <= n_serial;
            r_seq        <= n_seq;
            r_stored_crc <= n_stored_crc;
            r_seg_total  <= n_seg_total;
            r_seg_left   <= n_seg_left;
            r_body_total <= n_body_total;
            r_body_left  <= n_body_left;
            r_run        <= n_run;
            r_packets    <= n_packets;
            r_tail       <= n_tail;
            r_crc        <= n_crc;
        end
    end

endmodule

// File: rtl/opp_queue.sv
// Short result queue between the parser front end and the output back end.
// Holds Q_DEPTH entries of t_rec from opp_pkg.
module opp_queue
    import opp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    output logic o_valid,
    output t_rec o_head,
    input  logic i_pop
);

    t_rec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/opp_back.sv
// Back end: splits each queue entry into one or two result beats.
// Uses opp_pkg and opp_out_if.
module opp_back
    import opp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_rec       i_head,
    output logic       o_pop,
    opp_out_if.source  o_out
);

    logic  r_beat;
    logic  w_last;
    logic  w_fire;
    logic  w_hdr;
    t_kind w_kind;

    assign w_kind = (i_head.two && r_beat) ? i_head.kind1 : i_head.kind0;
    assign w_last = !i_head.two || r_beat;
    assign w_fire = i_valid && o_out.ready;
    assign o_pop  = w_fire && w_last;
    assign w_hdr  = (w_kind == K_PACKET) || (w_kind == K_SUMMARY);

    assign o_out.valid          = i_valid;
    assign o_out.kind           = w_kind;
    assign o_out.length         = (w_kind == K_PACKET)  ? i_head.len_pkt :
                                  (w_kind == K_SUMMARY) ? i_head.len_body : 16'h0000;
    assign o_out.last_of_run    = w_last;
    assign o_out.page_type      = w_hdr ? i_head.page_type : 8'h00;
    assign o_out.granule_low    = w_hdr ? i_head.gran_lo : 32'h0;
    assign o_out.granule_high   = w_hdr ? i_head.gran_hi : 32'h0;
    assign o_out.stream_serial  = w_hdr ? i_head.serial : 32'h0;
    assign o_out.page_sequence  = w_hdr ? i_head.sequence_no : 32'h0;
    assign o_out.segment_count  = w_hdr ? i_head.seg_count : 8'h00;
    assign o_out.packet_count   = w_hdr ? i_head.pkt_count : 8'h00;
    assign o_out.continued_tail = w_hdr && i_head.ctail;
    assign o_out.crc_ok         = (w_kind == K_SUMMARY) && i_head.crc_ok;

    // advance to the second beat, or back to the first once the entry is gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= 1'b0;
        end else if (w_fire) begin
            r_beat <= !w_last;
        end
    end

endmodule

// File: rtl/ogg_page_parser_crc_check.sv
// Top level of the Ogg page parser with page CRC check.
// Uses opp_pkg, opp_in_if, opp_out_if, opp_front, opp_queue, opp_back.
//
//  channel  dir  payload                                        beat
//  i_in     in   data_byte, end_of_buffer                       one stream byte
//  o_out    out  kind, length, last_of_run, page header, flags  one result
//
// One byte is taken per cycle while the queue is not full; the parser and
// the 8-step CRC update close in that cycle. A byte's results (zero, one or
// two beats) wait in a two-entry queue; a two-beat entry is popped after
// its second beat. i_in.ready drops only while the queue is full, so output
// stalls reach the input after two pending entries. Reset is synchronous and
// restarts the parser at the capture pattern with an empty queue.
module ogg_page_parser_crc_check
    import opp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    opp_in_if.sink     i_in,
    opp_out_if.source  o_out
);

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    t_rec w_rec;
    t_rec w_head;

    opp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_rec   (w_rec)
    );

    opp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    opp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("result pushed into a full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == K_SUMMARY) |-> o_out.last_of_run)
        else $error("page summary not the last beat of its byte");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == K_BAD_CAPTURE || o_out.kind == K_BAD_VERSION ||
                         o_out.kind == K_TRUNC))
        |-> (o_out.length == 16'h0000 && o_out.segment_count == 8'h00 && !o_out.crc_ok))
        else $error("error result carries page fields");
`endif

endmodule
